>>> hw/rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the lottery ticket scheduler
// Holds slot and ticket widths, request codes, register indexes, generator
// reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int FIELD_SLOT_W = 6;
    localparam int TICKET_W   = 16;
    localparam int ARRIVAL_W  = 31;
    localparam int ENTRY_W    = TICKET_W + ARRIVAL_W;
    localparam int SUM_W      = TICKET_W + SLOT_W;
    localparam int GEN_W      = 64;
    localparam int RND_W      = 32;
    localparam int CFG_IDX_W  = 8;

    localparam int GEN_SHL_A = 23;
    localparam int GEN_SHR_S = 17;
    localparam int GEN_SHR_T = 26;

    localparam logic [GEN_W-1:0] GEN_A_RESET = 64'd1234567890123456789;
    localparam logic [GEN_W-1:0] GEN_B_RESET = 64'd9876543210987654321;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_GEN,
        ST_DIV,
        ST_FIND,
        ST_TIE,
        ST_DONE
    } lts_state_t;

endpackage

>>> hw/rtl/lts_if.sv
// ----------------------------------------------------------------------------
// lts_if: handshake channels of the lottery ticket scheduler
// Request, response and configuration channels, each with valid, ready and
// its payload, seen from a source and from a sink.
// ----------------------------------------------------------------------------
interface lts_req_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [lts_pkg::FIELD_SLOT_W-1:0]  slot;
    logic [lts_pkg::TICKET_W-1:0]      tickets;
    logic [lts_pkg::ARRIVAL_W-1:0]     arrive_tick;
    logic                              runnable;

    modport source (output valid, func, slot, tickets, arrive_tick, runnable,
                    input ready);
    modport sink   (input valid, func, slot, tickets, arrive_tick, runnable,
                    output ready);
endinterface

interface lts_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              winner_found;
    logic [lts_pkg::FIELD_SLOT_W-1:0]  winner_slot;

    modport source (output valid, winner_found, winner_slot, input ready);
    modport sink   (input valid, winner_found, winner_slot, output ready);
endinterface

interface lts_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lts_pkg::CFG_IDX_W-1:0]     index;
    logic [lts_pkg::GEN_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lts_ram.sv
// ----------------------------------------------------------------------------
// lts_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lts_div.sv
// ----------------------------------------------------------------------------
// lts_div: iterative remainder unit
// Restoring division of a random word by the ticket total, one quotient bit
// per cycle; pulses done when the remainder is final.
// ----------------------------------------------------------------------------
module lts_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lts_pkg::RND_W-1:0] dividend,
    input  logic [lts_pkg::SUM_W-1:0] divisor,
    output logic                      done,
    output logic [lts_pkg::SUM_W-1:0] remainder
);

    localparam int CNT_W = $clog2(lts_pkg::RND_W + 1);

    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [lts_pkg::RND_W-1:0]   quo_reg, quo_next;
    logic [lts_pkg::SUM_W-1:0]   rem_reg, rem_next;
    logic [lts_pkg::SUM_W-1:0]   div_reg, div_next;
    logic [lts_pkg::SUM_W:0]     rem_shift;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        rem_shift = {rem_reg, quo_reg[lts_pkg::RND_W-1]};
        if (start)
        begin
            cnt_next = CNT_W'(lts_pkg::RND_W);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift in one dividend bit, subtract when it fits
            quo_next = {quo_reg[lts_pkg::RND_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, div_reg})
            begin
                rem_next = lts_pkg::SUM_W'(rem_shift - {1'b0, div_reg});
            end
            else
            begin
                rem_next = rem_shift[lts_pkg::SUM_W-1:0];
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/lottery_ticket_scheduler.sv
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler: lottery draw over a table of process slots
// Stores ticket counts, arrival ticks and runnable flags; a draw picks a
// winner by weighted random ticket with an earliest-arrival tie-break.
// ----------------------------------------------------------------------------
// req - request words: func selects load (write one slot: tickets,
//   arrive_tick, runnable) or draw. Taken only while idle; a load completes
//   in the cycle it is accepted.
// rsp - one word per draw: winner_found and winner_slot (zero when the
//   runnable ticket total is zero). Loads give no word.
// cfg - register writes, always ready: index 0 loads generator word A,
//   index 1 word B; drop other indexes.
// Sequence: sum walk over the slot RAM, generator step, bit-serial remainder,
//   find walk (ends early at the winner), tie-break walk, post; the walks
//   read one slot at a time through the single RAM read port. An empty
//   lottery posts after the sum walk. Ready returns in the same cycle as
//   the word is posted.
// Reset: runnable flags clear, generator words take their seed values, the
//   slot RAM is not cleared. If rsp stalls, hold the word in the output
//   register; loads are still taken, a later draw waits until it is taken.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler (
    input  logic     clk,
    input  logic     rst_n,
    lts_req_if.sink  req,
    lts_rsp_if.source rsp,
    lts_cfg_if.sink  cfg
);

    localparam int SW = lts_pkg::SLOT_W;
    localparam int TW = lts_pkg::TICKET_W;
    localparam int AW = lts_pkg::ARRIVAL_W;
    localparam int UW = lts_pkg::SUM_W;
    localparam int GW = lts_pkg::GEN_W;
    localparam int RW = lts_pkg::RND_W;
    localparam int N  = lts_pkg::SLOT_COUNT;

    lts_pkg::lts_state_t state_reg, state_next;

    logic [SW:0]           cnt_reg, cnt_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [SW-1:0]         rd_idx_reg, rd_idx_next;
    logic [UW-1:0]         acc_reg, acc_next;
    logic [UW-1:0]         total_reg, total_next;
    logic [UW-1:0]         target_reg, target_next;
    logic [SW-1:0]         win_reg, win_next;
    logic [TW-1:0]         win_tk_reg, win_tk_next;
    logic [AW-1:0]         win_ar_reg, win_ar_next;
    logic                  found_reg, found_next;
    logic [GW-1:0]         gen_a_reg, gen_a_next;
    logic [GW-1:0]         gen_b_reg, gen_b_next;
    logic [N-1:0]          flags_reg, flags_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [SW-1:0]         out_slot_reg, out_slot_next;

    // slot RAM: {arrival, tickets}
    logic                          ram_we;
    logic [SW-1:0]                 ram_waddr;
    logic [lts_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [SW-1:0]                 ram_raddr;
    logic [lts_pkg::ENTRY_W-1:0]   ram_rdata;

    logic                  div_start;
    logic [RW-1:0]         div_dividend;
    logic                  div_done;
    logic [UW-1:0]         div_rem;

    // scan datapath
    logic                  issue;
    logic [TW-1:0]         rd_tk;
    logic [AW-1:0]         rd_ar;
    logic                  rd_live;
    logic                  rd_last;
    logic [UW-1:0]         acc_add;

    // generator step
    logic [GW-1:0]         gen_s;
    logic [GW-1:0]         gen_new;
    logic [GW-1:0]         gen_out;

    logic                  req_fire;
    logic                  slot_ok;

    lts_ram #(
        .WIDTH (lts_pkg::ENTRY_W),
        .DEPTH (N)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign req.ready = (state_reg == lts_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign slot_ok   = (32'(req.slot) < N);
    assign cfg.ready = 1'b1;

    assign rsp.valid        = out_valid_reg;
    assign rsp.winner_found = out_found_reg;
    assign rsp.winner_slot  = lts_pkg::FIELD_SLOT_W'(out_slot_reg);

    // RAM write comes from loads only
    assign ram_we    = req_fire && (req.func == lts_pkg::FUNC_LOAD) && slot_ok;
    assign ram_waddr = SW'(req.slot);
    assign ram_wdata = {req.arrive_tick, req.tickets};
    assign ram_raddr = cnt_reg[SW-1:0];

    // returned read data belongs to rd_idx_reg
    assign issue   = (cnt_reg < (SW+1)'(N));
    assign rd_tk   = ram_rdata[TW-1:0];
    assign rd_ar   = ram_rdata[lts_pkg::ENTRY_W-1:TW];
    assign rd_live = rd_vld_reg && flags_reg[rd_idx_reg];
    assign rd_last = rd_vld_reg && (rd_idx_reg == SW'(N - 1));
    assign acc_add = acc_reg + (rd_live ? UW'(rd_tk) : UW'(0));

    // xorshift128+ step
    assign gen_s   = gen_a_reg ^ (gen_a_reg << lts_pkg::GEN_SHL_A);
    assign gen_new = gen_s ^ gen_b_reg ^ (gen_s >> lts_pkg::GEN_SHR_S)
                   ^ (gen_b_reg >> lts_pkg::GEN_SHR_T);
    assign gen_out = gen_new + gen_b_reg;
    assign div_dividend = gen_out[GW-1:GW-RW];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        target_next    = target_reg;
        win_next       = win_reg;
        win_tk_next    = win_tk_reg;
        win_ar_next    = win_ar_reg;
        found_next     = found_reg;
        gen_a_next     = gen_a_reg;
        gen_b_next     = gen_b_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_slot_next  = out_slot_reg;
        div_start      = 1'b0;

        // drop the posted word once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // advance the read pointer in every walk state
        if ((state_reg == lts_pkg::ST_SUM) || (state_reg == lts_pkg::ST_FIND)
            || (state_reg == lts_pkg::ST_TIE))
        begin
            rd_vld_next = issue;
            rd_idx_next = cnt_reg[SW-1:0];
            if (issue)
            begin
                cnt_next = cnt_reg + (SW+1)'(1);
            end
        end

        unique case (state_reg)
            lts_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.func == lts_pkg::FUNC_LOAD)
                    begin
                        if (slot_ok)
                        begin
                            flags_next[SW'(req.slot)] = req.runnable;
                        end
                    end
                    else
                    begin
                        cnt_next   = '0;
                        acc_next   = '0;
                        state_next = lts_pkg::ST_SUM;
                    end
                end
            end

            lts_pkg::ST_SUM:
            begin
                acc_next = acc_add;
                if (rd_last)
                begin
                    total_next = acc_add;
                    if (acc_add == '0)
                    begin
                        found_next = 1'b0;
                        win_next   = '0;
                        state_next = lts_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = lts_pkg::ST_GEN;
                    end
                end
            end

            lts_pkg::ST_GEN:
            begin
                gen_a_next = gen_b_reg;
                gen_b_next = gen_new;
                div_start  = 1'b1;
                state_next = lts_pkg::ST_DIV;
            end

            lts_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    target_next = div_rem + UW'(1);
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = lts_pkg::ST_FIND;
                end
            end

            lts_pkg::ST_FIND:
            begin
                acc_next = acc_add;
                if (rd_live && (acc_add >= target_reg))
                begin
                    win_next    = rd_idx_reg;
                    win_tk_next = rd_tk;
                    win_ar_next = rd_ar;
                    cnt_next    = '0;
                    rd_vld_next = 1'b0;
                    state_next  = lts_pkg::ST_TIE;
                end
                else if (rd_last)
                begin
                    cnt_next    = '0;
                    rd_vld_next = 1'b0;
                    state_next  = lts_pkg::ST_TIE;
                end
            end

            lts_pkg::ST_TIE:
            begin
                // an equal ticket count with a strictly earlier arrival wins
                if (rd_live && (rd_tk == win_tk_reg) && (rd_ar < win_ar_reg))
                begin
                    win_next    = rd_idx_reg;
                    win_ar_next = rd_ar;
                end
                if (rd_last)
                begin
                    found_next = 1'b1;
                    state_next = lts_pkg::ST_DONE;
                end
            end

            lts_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_slot_next  = win_reg;
                    state_next     = lts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lts_pkg::ST_IDLE;
            end
        endcase

        // register writes reload the generator
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                lts_pkg::CFG_SEED_FIRST:  gen_a_next = cfg.data;
                lts_pkg::CFG_SEED_SECOND: gen_b_next = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            gen_a_reg     <= lts_pkg::GEN_A_RESET;
            gen_b_reg     <= lts_pkg::GEN_B_RESET;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            gen_a_reg     <= gen_a_next;
            gen_b_reg     <= gen_b_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        acc_reg       <= acc_next;
        total_reg     <= total_next;
        target_reg    <= target_next;
        win_reg       <= win_next;
        win_tk_reg    <= win_tk_next;
        win_ar_reg    <= win_ar_next;
        out_found_reg <= out_found_next;
        out_slot_reg  <= out_slot_next;
    end

endmodule

>>> test/lottery_ticket_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler_test: self-checking bench of the lottery scheduler
// Drives load and draw words through the request channel and seed writes
// through the configuration channel. A local copy of the slot table and of
// the xorshift128+ generator predicts every draw. The bench compares each
// response word in order with the oldest prediction. A directed table comes
// first, then random phases under different seeds and handshake pressure.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler_test;

    localparam int CLK_HALF_NS     = 10;
    localparam int RESET_CYCLES    = 8;
    // Long enough for the longest draw to reach its word, with margin.
    localparam int QUIET_CYCLES    = 300;
    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int DIRECTED_ROWS   = 25;
    localparam int PHASE_COUNT     = 6;
    localparam int DRAW_PCT        = 30;

    localparam logic FUNC_LOAD = lts_pkg::FUNC_LOAD;
    localparam logic FUNC_DRAW = lts_pkg::FUNC_DRAW;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    // One request word as it crosses the request channel.
    typedef struct packed {
        logic                             func;
        logic [lts_pkg::FIELD_SLOT_W-1:0] slot;
        logic [lts_pkg::TICKET_W-1:0]     tickets;
        logic [lts_pkg::ARRIVAL_W-1:0]    arrive_tick;
        logic                             runnable;
    } sched_word_t;

    // One response word: the outcome of a draw.
    typedef struct packed {
        logic                             winner_found;
        logic [lts_pkg::FIELD_SLOT_W-1:0] winner_slot;
    } draw_outcome_t;

    // A row of the directed table: the word, and where the outcome is plain
    // to see, the outcome itself.
    typedef struct packed {
        sched_word_t   word;
        logic          known;
        draw_outcome_t outcome;
    } directed_row_t;

    localparam draw_outcome_t NO_WINNER = '{1'b0, 6'd0};

    logic clk;
    logic rst_n;

    lts_req_if req ();
    lts_rsp_if rsp ();
    lts_cfg_if cfg ();

    lottery_ticket_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // ------------------------------------------------------------------------
    // Local copy of the scheduler: generator words and the slot table.
    // ------------------------------------------------------------------------
    logic [lts_pkg::GEN_W-1:0]     rng_a;
    logic [lts_pkg::GEN_W-1:0]     rng_b;
    logic [lts_pkg::TICKET_W-1:0]  slot_tickets  [lts_pkg::SLOT_COUNT];
    logic [lts_pkg::ARRIVAL_W-1:0] slot_arrival  [lts_pkg::SLOT_COUNT];
    logic                          slot_runnable [lts_pkg::SLOT_COUNT];

    // Outcomes still owed by the block, oldest first.
    draw_outcome_t pending_winners [$];

    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    int unsigned runnable_pct  = 80;
    int unsigned rsp_hold_left = 0;

    directed_row_t directed_rows [DIRECTED_ROWS];
    draw_outcome_t got_winner;
    draw_outcome_t want_winner;

    // Run one lottery over the local table. Sum the runnable tickets, step
    // the generator, find the slot that holds the winning ticket, then hand
    // the win to an equal-ticket slot that arrived strictly earlier.
    function automatic draw_outcome_t pick_winner();
        logic [31:0]               total;
        logic [31:0]               running;
        logic [31:0]               target;
        logic [lts_pkg::GEN_W-1:0] s;
        logic [lts_pkg::GEN_W-1:0] t;
        logic [lts_pkg::GEN_W-1:0] mixed;
        int                        win;
        bit                        reached;
        total = 0;
        for (int i = 0; i < lts_pkg::SLOT_COUNT; i++)
        begin
            if (slot_runnable[i])
                total += slot_tickets[i];
        end
        // Empty lottery: no winner, and the generator stays put.
        if (total == 0)
            return NO_WINNER;
        s     = rng_a;
        t     = rng_b;
        rng_a = t;
        s     = s ^ (s << lts_pkg::GEN_SHL_A);
        rng_b = s ^ t ^ (s >> lts_pkg::GEN_SHR_S) ^ (t >> lts_pkg::GEN_SHR_T);
        mixed = rng_b + t;
        target  = mixed[lts_pkg::GEN_W-1:lts_pkg::RND_W] % total + 1;
        running = 0;
        win     = 0;
        reached = 1'b0;
        for (int i = 0; i < lts_pkg::SLOT_COUNT; i++)
        begin
            if (!reached && slot_runnable[i])
            begin
                running += slot_tickets[i];
                if (running >= target)
                begin
                    win     = i;
                    reached = 1'b1;
                end
            end
        end
        for (int i = 0; i < lts_pkg::SLOT_COUNT; i++)
        begin
            if (slot_runnable[i] && slot_tickets[i] == slot_tickets[win] &&
                slot_arrival[i] < slot_arrival[win])
                win = i;
        end
        return '{1'b1, win[lts_pkg::FIELD_SLOT_W-1:0]};
    endfunction

    // Report one mismatch.
    function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Write one register. Leave valid high on return so that back-to-back
    // writes need no second assignment in the same step; the caller drops it.
    task automatic write_register(input logic [lts_pkg::CFG_IDX_W-1:0] index,
                                  input logic [lts_pkg::GEN_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (index == lts_pkg::CFG_SEED_FIRST)
            rng_a = value;
        else if (index == lts_pkg::CFG_SEED_SECOND)
            rng_b = value;
        @(negedge clk);
    endtask

    // Offer one request word, idling first as the phase asks. On acceptance
    // update the local table or queue the predicted outcome. Return at the
    // next falling edge with valid still high.
    task automatic send_word(input sched_word_t word, input logic known,
                             input draw_outcome_t outcome);
        draw_outcome_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.func        <= word.func;
        req.slot        <= word.slot;
        req.tickets     <= word.tickets;
        req.arrive_tick <= word.arrive_tick;
        req.runnable    <= word.runnable;
        do
            @(posedge clk);
        while (!req.ready);
        if (word.func == FUNC_LOAD)
        begin
            // A non-runnable load still stores tickets and arrival.
            slot_tickets[word.slot]  = word.tickets;
            slot_arrival[word.slot]  = word.arrive_tick;
            slot_runnable[word.slot] = word.runnable;
        end
        else
        begin
            // Run the predictor even for typed rows so the generator keeps step.
            predicted = pick_winner();
            pending_winners.push_back(known ? outcome : predicted);
        end
        @(negedge clk);
    endtask

    // Drop valid, wait until every owed outcome has come, then give a load
    // or a late draw time to finish before the next register write.
    task automatic settle();
        req.valid <= 1'b0;
        @(negedge clk);
        while (pending_winners.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF_NS clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if the block hangs.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Response side: stall at random, or hold off for a counted stretch when
    // asked. Change ready only at the falling edge.
    // ------------------------------------------------------------------------
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_left != 0)
            begin
                rsp_hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each taken response word with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got_winner = '{rsp.winner_found, rsp.winner_slot};
            if (pending_winners.size() == 0)
                note_mismatch("unexpected response word, winner_slot", 0, got_winner.winner_slot);
            else
            begin
                want_winner = pending_winners.pop_front();
                if (got_winner.winner_found !== want_winner.winner_found)
                    note_mismatch("winner_found", want_winner.winner_found,
                                  got_winner.winner_found);
                if (got_winner.winner_slot !== want_winner.winner_slot)
                    note_mismatch("winner_slot", want_winner.winner_slot,
                                  got_winner.winner_slot);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, the directed table, then the random phases.
    // ------------------------------------------------------------------------
    initial
    begin
        sched_word_t word;
        int unsigned item_total;
        int unsigned pick;

        // Hold every input at a known value from time zero.
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.func        = FUNC_LOAD;
        req.slot        = '0;
        req.tickets     = '0;
        req.arrive_tick = '0;
        req.runnable    = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = lts_pkg::CFG_SEED_FIRST;
        cfg.data        = '0;

        // Mirror the reset state: seed words loaded, nothing runnable.
        rng_a = lts_pkg::GEN_A_RESET;
        rng_b = lts_pkg::GEN_B_RESET;
        for (int i = 0; i < lts_pkg::SLOT_COUNT; i++)
        begin
            slot_tickets[i]  = '0;
            slot_arrival[i]  = '0;
            slot_runnable[i] = 1'b0;
        end

        // Directed table. Typed outcomes follow from the slots that are
        // runnable at that point; the rest come from the predictor.
        directed_rows = '{
            // Draw right after reset: empty lottery.
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, TYPED,     NO_WINNER},
            // A single runnable slot at every field's maximum always wins.
            '{'{FUNC_LOAD, 6'd63, 16'hFFFF, 31'h7FFF_FFFF, 1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, TYPED,     '{1'b1, 6'd63}},
            // A zero-ticket slot can never hold the winning ticket.
            '{'{FUNC_LOAD, 6'd0,  16'h0000, 31'h0000_0000, 1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, TYPED,     '{1'b1, 6'd63}},
            // Equal tickets, earlier arrival: slot 5 takes every draw.
            '{'{FUNC_LOAD, 6'd5,  16'hFFFF, 31'h0000_0000, 1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, TYPED,     '{1'b1, 6'd5}},
            // Non-runnable load: stored but out of the lottery.
            '{'{FUNC_LOAD, 6'd5,  16'hFFFF, 31'h0000_0000, 1'b0}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, TYPED,     '{1'b1, 6'd63}},
            // Only the zero-ticket slot is left: empty lottery again.
            '{'{FUNC_LOAD, 6'd63, 16'hFFFF, 31'h7FFF_FFFF, 1'b0}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, TYPED,     NO_WINNER},
            // Equal tickets and equal arrival: the first pass winner stays.
            '{'{FUNC_LOAD, 6'd10, 16'd7,    31'd100,       1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_LOAD, 6'd20, 16'd7,    31'd100,       1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, PREDICTED, NO_WINNER},
            // A strictly earlier arrival among equal tickets wins every time.
            '{'{FUNC_LOAD, 6'd30, 16'd7,    31'd99,        1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, TYPED,     '{1'b1, 6'd30}},
            // Uneven weights; back-to-back draws leave the table alone.
            '{'{FUNC_LOAD, 6'd1,  16'd1,    31'd5,         1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_LOAD, 6'd2,  16'd3000, 31'd2,         1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, PREDICTED, NO_WINNER},
            // Alternating bit patterns in every field.
            '{'{FUNC_LOAD, 6'd42, 16'hAAAA, 31'h2AAA_AAAA, 1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_LOAD, 6'd21, 16'h5555, 31'h5555_5555, 1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd0,  16'h0000, 31'h0000_0000, 1'b0}, PREDICTED, NO_WINNER},
            // Bring slot 5 back; a draw ignores the other fields, all ones here.
            '{'{FUNC_LOAD, 6'd5,  16'hFFFF, 31'h0000_0000, 1'b1}, PREDICTED, NO_WINNER},
            '{'{FUNC_DRAW, 6'd63, 16'hFFFF, 31'h7FFF_FFFF, 1'b1}, PREDICTED, NO_WINNER}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table with no idling on either side.
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_word(directed_rows[r].word, directed_rows[r].known,
                      directed_rows[r].outcome);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            // Reseed only while the block is idle.
            settle();
            idle_pct     = 0;
            stall_pct    = 0;
            runnable_pct = 80;
            item_total   = 300;
            case (phase)
                0:
                begin
                    // All-zero seeds: the generator sticks at zero.
                    write_register(lts_pkg::CFG_SEED_FIRST, '0);
                    write_register(lts_pkg::CFG_SEED_SECOND, '0);
                end
                1:
                begin
                    write_register(lts_pkg::CFG_SEED_FIRST, '1);
                    write_register(lts_pkg::CFG_SEED_SECOND, '1);
                    idle_pct = 88;
                end
                2:
                begin
                    write_register(lts_pkg::CFG_SEED_FIRST, {$urandom, $urandom});
                    write_register(lts_pkg::CFG_SEED_SECOND, {$urandom, $urandom});
                    stall_pct = 88;
                end
                3:
                begin
                    write_register(lts_pkg::CFG_SEED_FIRST, lts_pkg::GEN_A_RESET);
                    write_register(lts_pkg::CFG_SEED_SECOND, {$urandom, $urandom});
                    idle_pct     = 32;
                    stall_pct    = 32;
                    runnable_pct = 20;
                end
                4:
                begin
                    write_register(lts_pkg::CFG_SEED_FIRST, {$urandom, $urandom});
                    write_register(lts_pkg::CFG_SEED_SECOND, {$urandom, $urandom});
                    item_total = 400;
                end
                default:
                begin
                    // Reverse order, and the two extremes side by side.
                    write_register(lts_pkg::CFG_SEED_SECOND, '1);
                    write_register(lts_pkg::CFG_SEED_FIRST, 64'd1);
                    idle_pct   = 32;
                    stall_pct  = 32;
                    item_total = 400;
                end
            endcase
            // An unknown index must leave both generator words alone.
            write_register(lts_pkg::CFG_IDX_W'($urandom_range(255,
                                                lts_pkg::CFG_SEED_SECOND + 1)),
                           {$urandom, $urandom});
            cfg.valid <= 1'b0;

            if (phase == 4)
            begin
                // Hold the response side off for a long stretch while words
                // keep coming, so the block fills up and stalls its input.
                @(posedge clk);
                rsp_hold_left = HOLD_OFF_CYCLES;
                @(negedge clk);
            end

            for (int n = 0; n < item_total; n++)
            begin
                if (phase == 4 && n == item_total / 2)
                begin
                    // Pause the sender until every owed outcome has come.
                    req.valid <= 1'b0;
                    @(negedge clk);
                    while (pending_winners.size() != 0)
                        @(negedge clk);
                end
                word.tickets     = 16'($urandom);
                word.arrive_tick = 31'($urandom);
                word.slot        = lts_pkg::FIELD_SLOT_W'($urandom);
                word.runnable    = 1'($urandom);
                if (phase == 3 && n < lts_pkg::SLOT_COUNT)
                begin
                    // Sweep the table in order first so that few slots stay
                    // runnable.
                    word.func     = FUNC_LOAD;
                    word.slot     = lts_pkg::FIELD_SLOT_W'(n);
                    word.runnable = ($urandom_range(99) < runnable_pct);
                end
                else if ($urandom_range(99) < DRAW_PCT)
                    word.func = FUNC_DRAW;
                else
                begin
                    word.func     = FUNC_LOAD;
                    word.runnable = ($urandom_range(99) < runnable_pct);
                end
                if (word.func == FUNC_LOAD)
                begin
                    // Favor small ticket and arrival values so that ties
                    // come up often; keep the extremes in the mix.
                    pick = $urandom_range(9);
                    if (pick == 0)
                        word.tickets = '0;
                    else if (pick == 1)
                        word.tickets = '1;
                    else if (pick <= 4)
                        word.tickets = 16'($urandom_range(4, 1));
                    else if (pick <= 6)
                        word.tickets = 16'($urandom_range(255, 1));
                    pick = $urandom_range(9);
                    if (pick == 0)
                        word.arrive_tick = '0;
                    else if (pick == 1)
                        word.arrive_tick = '1;
                    else if (pick <= 4)
                        word.arrive_tick = 31'($urandom_range(7));
                end
                send_word(word, PREDICTED, NO_WINNER);
            end
        end

        // Drain: wait for every owed outcome, then for one more draw's worth.
        req.valid <= 1'b0;
        @(negedge clk);
        while (pending_winners.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
